// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MOVE  = 2'd2,
    OP_READ  = 2'd3
  } tcw_op_t;

  localparam logic [CFG_IDX_W-1:0] REG_FG     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_EN = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming word
    logic exec;       // carry out the command on cursor and store
    logic fill;       // write one cell of a sweep
    logic fill_zero;  // sweep writes zero instead of blanks
    logic scroll;     // one copy step of a scroll
    logic finish;     // load the result register
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    tcw_op_t op;
    logic    need_scroll;
    logic    fill_last;
    logic    scroll_last;
    logic    out_free;
  } tcw_stat_t;

endpackage

// ===== rtl/tcw_datapath.sv =====
// Datapath of the text console writer: cell store, cursor, registers and result word.
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  tcw_cmd_t               cmd,
  output tcw_stat_t              stat,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int CELLS    = ROWS * COLS;
  localparam int SCROLL_N = (ROWS - 1) * COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int COL_W    = $clog2(COLS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int CUR_W    = $clog2(CELLS + 2);

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  tcw_op_t           op;
  logic [7:0]        ch;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [3:0]        fg;
  logic [3:0]        bg;
  logic              cur_en;
  logic [ADDR_W-1:0] cnt;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  logic [6:0]        sat_col;
  logic [6:0]        sat_row;
  logic [7:0]        attr;
  logic              is_nl, is_cr, is_bs, is_plain;
  logic              col_last, row_last;
  logic [ADDR_W-1:0] cur_pos, cell_pos;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CUR_W-1:0]  cur_lin;
  logic [CUR_W+10:0] cur_ext;

  // saturate the requested position
  always_comb begin
    sat_col = (in_data[16:10] > 7'(COLS - 1)) ? 7'(COLS - 1) : in_data[16:10];
    sat_row = ({2'b00, in_data[21:17]} > 7'(ROWS - 1)) ? 7'(ROWS - 1)
                                                       : {2'b00, in_data[21:17]};
  end

  assign attr     = {bg, fg};
  assign is_nl    = (ch == CH_NEWLINE);
  assign is_cr    = (ch == CH_RETURN);
  assign is_bs    = (ch == CH_BACKSPACE);
  assign is_plain = !is_nl && !is_cr && !is_bs;
  assign col_last = (cur_col == COL_W'(COLS - 1));
  assign row_last = (cur_row == ROW_W'(ROWS - 1));
  assign cur_pos  = ADDR_W'(cur_row) * ADDR_W'(COLS) + ADDR_W'(cur_col);
  assign cell_pos = ADDR_W'(in_row) * ADDR_W'(COLS) + ADDR_W'(in_col);

  assign stat.op          = op;
  assign stat.need_scroll = (op == OP_PUT) && row_last && (is_nl || (is_plain && col_last));
  assign stat.fill_last   = (cnt == ADDR_W'(CELLS - 1));
  assign stat.scroll_last = (cnt == ADDR_W'(SCROLL_N - 1));
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= tcw_op_t'(in_data[1:0]);
      ch     <= in_data[9:2];
      in_col <= COL_W'(sat_col);
      in_row <= ROW_W'(sat_row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg     <= 4'd7;
      bg     <= 4'd0;
      cur_en <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_FG) fg <= cfg_data;
      if (cfg_index == REG_BG) bg <= cfg_data;
      if (cfg_index == REG_CUR_EN) cur_en <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else if (cmd.exec) begin
      case (op)
        OP_PUT: begin
          if (is_nl || (is_plain && col_last)) begin
            cur_col <= '0;
            if (!row_last) cur_row <= cur_row + 1'b1;
          end else if (is_cr) begin
            cur_col <= '0;
          end else if (is_bs) begin
            if (cur_col != '0) cur_col <= cur_col - 1'b1;
          end else begin
            cur_col <= cur_col + 1'b1;
          end
        end
        OP_CLEAR: begin
          cur_col <= '0;
          cur_row <= '0;
        end
        OP_MOVE: begin
          cur_col <= in_col;
          cur_row <= in_row;
        end
        default: ;
      endcase
    end
  end

  // single write port: scroll copy, sweep, or character
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_pos;
    wr_data = {attr, ch};
    if (pend) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_data = rdata;
    end else if (cmd.fill) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = cmd.fill_zero ? 16'h0000 : {attr, CH_BLANK};
    end else if (cmd.exec && op == OP_PUT && is_plain) begin
      wr_en   = 1'b1;
    end
  end

  assign rd_en   = cmd.scroll || (cmd.exec && op == OP_READ);
  assign rd_addr = cmd.scroll ? cnt + ADDR_W'(COLS) : cell_pos;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.scroll;
      if (cmd.fill) cnt <= stat.fill_last ? '0 : cnt + 1'b1;
      else if (cmd.scroll) cnt <= stat.scroll_last ? '0 : cnt + 1'b1;
    end
  end

  // copied cell lands one row up in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.scroll) pend_addr <= cnt;
  end

  assign cur_lin = cur_en ? CUR_W'(cur_pos) : CUR_W'(CELLS + 1);
  assign cur_ext = {11'b0, cur_lin};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {5'b0, cur_ext[10:0], (op == OP_READ) ? rdata : 16'h0000};
    end
  end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller of the text console writer: sequences each command and the store sweeps.
module tcw_ctrl import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output tcw_cmd_t  cmd,
  input  tcw_stat_t stat
);

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      unique case (state)
        ST_WIPE:   if (stat.fill_last) state <= ST_IDLE;
        ST_IDLE:   if (in_valid) state <= ST_EXEC;
        ST_EXEC: begin
          if (stat.op == OP_CLEAR) state <= ST_CLEAR;
          else if (stat.need_scroll) state <= ST_SCROLL;
          else state <= ST_FINISH;
        end
        ST_CLEAR:  if (stat.fill_last) state <= ST_FINISH;
        ST_SCROLL: if (stat.scroll_last) state <= ST_FINISH;
        ST_FINISH: if (stat.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.exec      = (state == ST_EXEC);
    cmd.fill      = (state == ST_WIPE) || (state == ST_CLEAR);
    cmd.fill_zero = (state == ST_WIPE);
    cmd.scroll    = (state == ST_SCROLL);
    cmd.finish    = (state == ST_FINISH) && stat.out_free;
  end

endmodule

// ===== rtl/text_console_writer_top.sv =====
// Text console writer: a ROWS x COLS cell store with cursor, driven by a word stream.
// Each input word carries one command and yields one result word. An accepted word is
// latched, carried out in the execute state and loaded into the result register in the
// finish state once the output register is free; no new word is taken before that.
// Before the finish state clear_screen sweeps all ROWS*COLS cells and a scrolling
// put_char copies (ROWS-1)*COLS cells, both on the single write port, one cell a cycle.
// After reset the block sweeps all ROWS*COLS cells of the store (2000 at the default
// size) to zero before it takes its first word; register writes are taken throughout.
// A finished result may wait in the output register while the next word is accepted.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[1:0], character[9:2], column[16:10], row[21:17]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // cell_data[15:0], cursor_register[26:16]
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checks for the text console writer and their binding to the top level.
module tcw_checker import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CELLS = ROWS * COLS;

  logic [1:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // words accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("block not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 2'd0)
    else $error("result word without an accepted input word");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two words in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CELLS + 1 >= 2048) || (32'(m_tdata[26:16]) <= 32'(CELLS + 1)))
    else $error("cursor register out of range");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
